/* rtl/core/jcc_pkg.sv */
// ----------------------------------------------------------------------------
// jcc_pkg
// Shared types and constants for the JSON content-type classifier.
// ----------------------------------------------------------------------------
package jcc_pkg;

  localparam int unsigned EXACT_LEN  = 16;
  localparam int unsigned PREFIX_LEN = 12;
  localparam int unsigned SUFFIX_LEN = 5;

  localparam logic [4:0] KEPT_MAX   = 5'd31;
  localparam logic [2:0] BLANKS_MAX = 3'd5;
  localparam logic [4:0] EXACT_LEN_W  = 5'd16;
  localparam logic [4:0] PREFIX_LEN_W = 5'd12;
  localparam logic [4:0] SUFFIX_MIN_W = 5'd18;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [39:0] SUFFIX_WORD = 40'h2B6A736F6E;

  localparam logic [7:0] EXACT_TEXT [EXACT_LEN] = '{
    8'h61, 8'h70, 8'h70, 8'h6C, 8'h69, 8'h63, 8'h61, 8'h74,
    8'h69, 8'h6F, 8'h6E, 8'h2F, 8'h6A, 8'h73, 8'h6F, 8'h6E
  };

  typedef enum logic [2:0] {
    PH_LEAD   = 3'b001,
    PH_TYPE   = 3'b010,
    PH_IGNORE = 3'b100
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } jcc_item_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

/* rtl/core/jcc_in_stage.sv */
// ----------------------------------------------------------------------------
// jcc_in_stage
// Input register: holds one header byte until the classifier takes it.
// ----------------------------------------------------------------------------
module jcc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               take,
  output jcc_pkg::jcc_item_t item
);
  import jcc_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;

  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (in_valid && in_ready) begin
      vld_nxt  = 1'b1;
      data_nxt = in_char_byte;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign item.vld  = vld_r;
  assign item.data = data_r;

`ifndef SYNTHESIS
  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> vld_r)
    else $error("take without a held byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !take) |=> (vld_r && $stable(data_r)))
    else $error("held byte lost while stalled");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (vld_r && data_r == $past(in_char_byte)))
    else $error("accepted byte not loaded");
`endif

endmodule

/* rtl/core/jcc_classify.sv */
// ----------------------------------------------------------------------------
// jcc_classify
// Trim/match state update per byte and the registered result.
// ----------------------------------------------------------------------------
module jcc_classify (
  input  logic               clk,
  input  logic               rst_n,
  input  jcc_pkg::jcc_item_t item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_verdict
);
  import jcc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  kept_r, kept_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        exact_r, exact_nxt;
  logic        prefix_r, prefix_nxt;
  logic [39:0] win_r, win_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_verdict_r, out_verdict_nxt;

  logic        out_free;
  logic        is_zero, is_semi, is_blank;
  logic [7:0]  lc;
  logic [5:0]  sum;
  logic [4:0]  pos_c;
  logic [4:0]  kept_keep;
  logic        exact_keep, prefix_keep;
  logic [39:0] win_keep;
  logic        elig;

  assign out_free = !out_valid_r || out_ready;
  assign is_zero  = (item.data == CH_NUL);
  assign is_semi  = (item.data == CH_SEMI);
  assign is_blank = (item.data == CH_SPACE) || (item.data == CH_TAB);
  assign take     = item.vld && (!is_zero || out_free);
  assign lc       = to_lower(item.data);

  // flush pending blanks as spaces, then keep the byte
  always_comb begin
    sum   = {1'b0, kept_r} + {3'b000, pend_r};
    pos_c = (sum > {1'b0, KEPT_MAX}) ? KEPT_MAX : sum[4:0];
    kept_keep = (pos_c == KEPT_MAX) ? KEPT_MAX : pos_c + 5'd1;
    exact_keep = exact_r
      && !(pend_r != 3'd0 && kept_r < EXACT_LEN_W)
      && !(pos_c < EXACT_LEN_W && lc != EXACT_TEXT[pos_c[3:0]]);
    prefix_keep = prefix_r
      && !(pend_r != 3'd0 && kept_r < PREFIX_LEN_W)
      && !(pos_c < PREFIX_LEN_W && lc != EXACT_TEXT[pos_c[3:0]]);
    win_keep = win_r;
    for (int i = 0; i < int'(BLANKS_MAX); i++) begin
      if (3'(i) < pend_r) begin
        win_keep = {win_keep[31:0], CH_SPACE};
      end
    end
    win_keep = {win_keep[31:0], lc};
  end

  assign elig = (kept_r != 5'd0) &&
                ((exact_r && kept_r == EXACT_LEN_W) ||
                 (prefix_r && kept_r >= SUFFIX_MIN_W && win_r == SUFFIX_WORD));

  always_comb begin
    phase_nxt       = phase_r;
    kept_nxt        = kept_r;
    pend_nxt        = pend_r;
    exact_nxt       = exact_r;
    prefix_nxt      = prefix_r;
    win_nxt         = win_r;
    out_verdict_nxt = out_verdict_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (take) begin
      if (is_zero) begin
        out_valid_nxt   = 1'b1;
        out_verdict_nxt = elig;
        phase_nxt       = PH_LEAD;
        kept_nxt        = 5'd0;
        pend_nxt        = 3'd0;
        exact_nxt       = 1'b1;
        prefix_nxt      = 1'b1;
        win_nxt         = '0;
      end else begin
        unique case (phase_r)
          PH_IGNORE: begin
          end
          PH_LEAD, PH_TYPE: begin
            if (is_semi) begin
              phase_nxt = PH_IGNORE;
            end else if (is_blank) begin
              if (phase_r == PH_TYPE && pend_r < BLANKS_MAX) begin
                pend_nxt = pend_r + 3'd1;
              end
            end else begin
              phase_nxt  = PH_TYPE;
              kept_nxt   = kept_keep;
              pend_nxt   = 3'd0;
              exact_nxt  = exact_keep;
              prefix_nxt = prefix_keep;
              win_nxt    = win_keep;
            end
          end
          default: begin
            phase_nxt = PH_IGNORE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      kept_r      <= 5'd0;
      pend_r      <= 3'd0;
      exact_r     <= 1'b1;
      prefix_r    <= 1'b1;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      kept_r      <= kept_nxt;
      pend_r      <= pend_nxt;
      exact_r     <= exact_nxt;
      prefix_r    <= prefix_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= BLANKS_MAX)
    else $error("pending blanks over limit");

  a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEAD) |-> (kept_r == 5'd0 && pend_r == 3'd0))
    else $error("leading phase with kept text");

  a_pend_in_type: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 3'd0) |-> (phase_r != PH_LEAD))
    else $error("pending blanks in leading phase");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_zero) |=> (out_valid_r && phase_r == PH_LEAD && kept_r == 5'd0))
    else $error("terminator did not produce result and reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_verdict_r)))
    else $error("pending result overwritten");
`endif

endmodule

/* rtl/core/json_content_type_classifier_unit.sv */
// ----------------------------------------------------------------------------
// json_content_type_classifier_unit
// Classifies a NUL-terminated Content-Type value as JSON-eligible or not.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a NUL stalls only while a prior result waits.
// Path: an accepted NUL byte sits in the input register (held while a prior result
//   waits), then its state update loads the result register.
// Only the NUL byte produces a result; other bytes update match state only.
// Reset (rst_n low, synchronous) empties both registers and restores the
//   leading-blank state; no clearing pass is needed.
module json_content_type_classifier_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_verdict
);
  import jcc_pkg::*;

  jcc_item_t item;
  logic      take;

  jcc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .take         (take),
    .item         (item)
  );

  jcc_classify u_cls (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_content_type_classifier_unit.
// Header strings are sent one byte per transaction and closed by a NUL byte.
// A byte-level predictor tracks trimming, blanks, the exact match, the prefix
// match and the suffix window, and queues the expected kind for every NUL.
// A fixed table of corner strings runs first. Random headers follow: mostly
// well-formed JSON types in mixed case, plus broken variants and raw noise.
// Random gaps are used on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jcc_pkg::*;

  localparam int   NO_KIND   = -1;
  localparam logic KIND_SKIP = 1'b0;
  localparam logic KIND_JSON = 1'b1;
  localparam int   N_DIR     = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_verdict;

  json_content_type_classifier_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_verdict  (out_verdict)
  );

  always #2 clk = ~clk;

  // predictor state
  phase_t      cls_phase;
  logic [4:0]  kept_len;
  logic [2:0]  blank_run;
  logic        exact_hit;
  logic        prefix_hit;
  logic [39:0] tail_lc;

  logic        pending_kinds [$];
  logic [7:0]  hdr_bytes [$];
  int          err_count = 0;
  int          sent_bytes = 0;
  int          seen_results = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  string       sub_chars = "abcvndxyzQ09.-_+";

  string dir_text [N_DIR] = '{
    "",
    " \t  \t",
    "application/json",
    "APPLICATION/JSON",
    " \tApplication/Json \t;charset=utf-8",
    "application/vnd.api+json",
    "application/+json",
    "application/x+json",
    "application/json5",
    "text/json",
    "application/ json",
    "application/x \t\t+json",
    "x       y",
    "application/json\377",
    "\200\377~\001",
    "application/vnd.example.really-long-name+JSON",
    ";application/json",
    "application/json ;",
    "application/jsonapplication/json",
    "text/plain+json"
  };

  int dir_kind [N_DIR] = '{
    KIND_SKIP, KIND_SKIP, KIND_JSON, KIND_JSON, KIND_JSON,
    KIND_JSON, KIND_SKIP, KIND_JSON, KIND_SKIP, KIND_SKIP,
    KIND_SKIP, NO_KIND,   NO_KIND,   KIND_SKIP, KIND_SKIP,
    NO_KIND,   KIND_SKIP, KIND_JSON, NO_KIND,   KIND_SKIP
  };

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  function void clear_classifier();
    cls_phase  = PH_LEAD;
    kept_len   = '0;
    blank_run  = '0;
    exact_hit  = 1'b1;
    prefix_hit = 1'b1;
    tail_lc    = '0;
  endfunction

  function void keep_lower(input logic [7:0] c);
    logic [7:0] lc;
    lc = fold_case(c);
    if (kept_len < EXACT_LEN) begin
      if (lc != EXACT_TEXT[kept_len]) exact_hit = 1'b0;
    end
    if (kept_len < PREFIX_LEN) begin
      if (lc != EXACT_TEXT[kept_len]) prefix_hit = 1'b0;
    end
    tail_lc = {tail_lc[31:0], lc};
    if (kept_len != KEPT_MAX) kept_len = kept_len + 5'd1;
  endfunction

  // returns 1 when the byte produces a result
  function bit classify_byte(input logic [7:0] c, output logic kind);
    kind = KIND_SKIP;
    if (c == CH_NUL) begin
      if (kept_len != 0) begin
        if (exact_hit && kept_len == EXACT_LEN_W) kind = KIND_JSON;
        if (prefix_hit && kept_len >= SUFFIX_MIN_W && tail_lc == SUFFIX_WORD) begin
          kind = KIND_JSON;
        end
      end
      clear_classifier();
      return 1'b1;
    end
    if (cls_phase == PH_IGNORE) return 1'b0;
    if (c == CH_SEMI) begin
      cls_phase = PH_IGNORE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (cls_phase == PH_TYPE && blank_run < BLANKS_MAX) blank_run = blank_run + 3'd1;
    end else begin
      while (blank_run != 0) begin
        keep_lower(CH_SPACE);
        blank_run = blank_run - 3'd1;
      end
      cls_phase = PH_TYPE;
      keep_lower(c);
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function void append_text(input string s, input bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'h20;
      hdr_bytes.push_back(c);
    end
  endfunction

  function void make_header();
    int  mode;
    int  idx;
    bit  suffix_form;
    hdr_bytes.delete();
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      repeat ($urandom_range(0, 20)) hdr_bytes.push_back(8'($urandom_range(1, 255)));
      return;
    end
    suffix_form = $urandom_range(0, 1);
    repeat ($urandom_range(0, 3)) hdr_bytes.push_back(blank_char());
    if (suffix_form) begin
      append_text("application/", 1'b1);
      repeat ($urandom_range(0, 7)) begin
        hdr_bytes.push_back(sub_chars[$urandom_range(0, sub_chars.len() - 1)]);
      end
      append_text("+json", 1'b1);
    end else begin
      append_text("application/json", 1'b1);
    end
    repeat ($urandom_range(0, 3)) hdr_bytes.push_back(blank_char());
    if ($urandom_range(0, 2) == 0) append_text(";charset=utf-8", 1'b1);
    if (mode >= 8) begin
      idx = $urandom_range(0, hdr_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: hdr_bytes[idx] = 8'($urandom_range(1, 255));
        1: hdr_bytes.insert(idx, blank_char());
        default: hdr_bytes.delete(idx);
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic send_header(input int typed_kind);
    logic kind;
    foreach (hdr_bytes[i]) begin
      send_byte(hdr_bytes[i]);
      void'(classify_byte(hdr_bytes[i], kind));
    end
    send_byte(CH_NUL);
    void'(classify_byte(CH_NUL, kind));
    pending_kinds.push_back(typed_kind == NO_KIND ? kind : logic'(typed_kind[0]));
  endtask

  // hold off input until every queued result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_kinds.size() != 0);
  endtask

  task automatic check_kind(input logic got);
    logic want;
    seen_results++;
    if (pending_kinds.size() == 0) begin
      report_mismatch($sformatf("result %0d kind=%0b with no transaction pending",
                                seen_results, got));
      return;
    end
    want = pending_kinds.pop_front();
    if (got !== want) begin
      report_mismatch($sformatf("result %0d kind got %0b want %0b", seen_results, got, want));
    end
  endtask

  // result side
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (seen_results % 8 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall = calm_out ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_kind(out_verdict);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int guard;
    clear_classifier();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      calm_in = (i % 4 == 0);
      hdr_bytes.delete();
      append_text(dir_text[i], 1'b0);
      send_header(dir_kind[i]);
    end
    drain_results();

    while (sent_bytes < 750) begin
      make_header();
      calm_in = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 24) == 0) drain_results();
      send_header(NO_KIND);
    end

    in_valid <= 1'b0;
    guard = 0;
    while (pending_kinds.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_kinds.size() != 0) begin
      report_mismatch($sformatf("%0d transactions never produced a result",
                                pending_kinds.size()));
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
